@@ rtl/fatlb_pkg.sv @@
// Shared sizes and control types for the fully associative translation buffer.
// No dependencies; imported by every module of the block.
package fatlb_pkg;

  localparam int ENTRIES    = 16;
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 20;

  // capacity register width is fixed by the register map
  localparam int CAP_W      = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam int RANK_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam int IN_DATA_W  = ((PAGE_BITS + FRAME_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((FRAME_BITS + PAGE_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  // tuser bit positions
  localparam int IN_USER_ACTION  = 0;
  localparam int OUT_USER_HIT    = 0;
  localparam int OUT_USER_EVICT  = 1;

  // action codes
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef struct packed {
    logic capture;  // register the accepted input transaction
    logic exec;     // run the lookup/update and load the result register
  } fatlb_cmd_t;

  typedef struct packed {
    logic out_free; // result register can take a new result this cycle
  } fatlb_sts_t;

endpackage

@@ rtl/fully_associative_lru_tlb_unit.sv @@
// Fully associative translation buffer with least-recently-used replacement.
// Each input transaction is first captured, then run through the parallel
// tag compare over all entries with the recency ranks written back in the same
// step; the input stays closed until that step has run, and it waits while the result
// register is full. Capacity is written through cfg_wr_en/cfg_wr_data (reset 16,
// zero disables the buffer); write it only while the unit is idle.
// Depends on fatlb_pkg, fatlb_ctrl and fatlb_dp.
module fully_associative_lru_tlb_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [fatlb_pkg::CAP_W-1:0]         cfg_wr_data,   // capacity_in_use
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fatlb_pkg::IN_DATA_W-1:0]     in_tdata,      // page_number, frame_in
  input  logic                                in_tuser,      // action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fatlb_pkg::OUT_DATA_W-1:0]    out_tdata,     // frame_out, evicted_page
  output logic [fatlb_pkg::OUT_USER_W-1:0]    out_tuser      // hit, evicted
);
  import fatlb_pkg::*;

  fatlb_cmd_t cmd;
  fatlb_sts_t sts;

  fatlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fatlb_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // an accepted transaction keeps the input closed for the execute cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted during execute");

  a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[OUT_USER_HIT] && out_tuser[OUT_USER_EVICT]))
    else $error("hit and eviction reported together");

  a_miss_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[OUT_USER_HIT]) |-> (out_tdata[FRAME_BITS-1:0] == '0))
    else $error("frame reported on miss");

  a_no_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[OUT_USER_EVICT])
      |-> (out_tdata[FRAME_BITS +: PAGE_BITS] == '0))
    else $error("evicted page reported without eviction");

endmodule

@@ rtl/fatlb_ctrl.sv @@
// Controller for the translation buffer: sequences capture and execute steps.
// Depends on fatlb_pkg for the command and status structs.
module fatlb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  fatlb_pkg::fatlb_sts_t sts,
  output fatlb_pkg::fatlb_cmd_t cmd
);
  import fatlb_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_WORK;
        end
      end
      S_WORK: begin
        // hold the item until the result register has room
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/fatlb_dp.sv @@
// Datapath for the translation buffer: entry storage, parallel tag compare,
// recency ranks, capacity register and result register. Depends on fatlb_pkg.
module fatlb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fatlb_pkg::fatlb_cmd_t               cmd,
  output fatlb_pkg::fatlb_sts_t               sts,
  input  logic                                cfg_wr_en,
  input  logic [fatlb_pkg::CAP_W-1:0]         cfg_wr_data,
  input  logic [fatlb_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fatlb_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [fatlb_pkg::OUT_USER_W-1:0]    out_tuser
);
  import fatlb_pkg::*;

  logic [CAP_W-1:0]      cap_r;

  logic                  act_r;
  logic [PAGE_BITS-1:0]  pg_r;
  logic [FRAME_BITS-1:0] fi_r;

  logic [ENTRIES-1:0]    valid_r, valid_nxt;
  logic [PAGE_BITS-1:0]  page_r  [ENTRIES];
  logic [PAGE_BITS-1:0]  page_nxt[ENTRIES];
  logic [FRAME_BITS-1:0] frame_r  [ENTRIES];
  logic [FRAME_BITS-1:0] frame_nxt[ENTRIES];
  logic [RANK_W-1:0]     rank_r  [ENTRIES];
  logic [RANK_W-1:0]     rank_nxt[ENTRIES];
  logic [CNT_W-1:0]      used_r, used_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    lru;
  logic [ENTRIES-1:0]    evict_vec;
  logic [ENTRIES-1:0]    valid_kept;
  logic [ENTRIES-1:0]    free_vec;
  logic [ENTRIES-1:0]    slot;
  logic                  hit;
  logic                  evicted;
  logic                  need_evict;
  logic                  enabled;
  logic [CMP_W-1:0]      cap_sat;
  logic [RANK_W-1:0]     hit_rank;
  logic [FRAME_BITS-1:0] hit_frame;
  logic [PAGE_BITS-1:0]  ev_page;
  logic [CNT_W-1:0]      lru_rank;

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_user_r;

  assign enabled  = (cap_r != '0);
  assign cap_sat  = (CMP_W'(cap_r) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_r);
  assign lru_rank = used_r - CNT_W'(1);

  always_comb begin
    hit_rank  = '0;
    hit_frame = '0;
    ev_page   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (page_r[i] == pg_r);
      // the oldest valid entry holds rank used_count-1
      lru[i]   = valid_r[i] && (CNT_W'(rank_r[i]) == lru_rank);
    end
    hit        = |match;
    need_evict = (CMP_W'(used_r) >= cap_sat) && (used_r != '0);
    evict_vec  = need_evict ? lru : '0;
    evicted    = |evict_vec;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank  = hit_rank  | (match[i]     ? rank_r[i]  : '0);
      hit_frame = hit_frame | (match[i]     ? frame_r[i] : '0);
      ev_page   = ev_page   | (evict_vec[i] ? page_r[i]  : '0);
    end
    valid_kept = valid_r & ~evict_vec;
    free_vec   = ~valid_kept;
    slot       = free_vec & (~free_vec + ENTRIES'(1));
  end

  always_comb begin
    valid_nxt    = valid_r;
    used_nxt     = used_r;
    page_nxt     = page_r;
    frame_nxt    = frame_r;
    rank_nxt     = rank_r;
    out_data_nxt = '0;
    out_user_nxt = '0;
    if (cmd.exec && enabled) begin
      if (hit) begin
        out_user_nxt[OUT_USER_HIT]     = 1'b1;
        out_data_nxt[FRAME_BITS-1:0]   = hit_frame;
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank_nxt[i] = '0;
            if (act_r == ACT_INSERT) begin
              frame_nxt[i] = fi_r;
            end
          end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
      end else if (act_r == ACT_INSERT) begin
        out_user_nxt[OUT_USER_EVICT]             = evicted;
        out_data_nxt[FRAME_BITS +: PAGE_BITS]    = ev_page;
        // drop the victim, age the rest, fill the lowest free entry
        valid_nxt = valid_kept | slot;
        used_nxt  = used_r - CNT_W'(evicted) + CNT_W'(|slot);
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot[i]) begin
            page_nxt[i]  = pg_r;
            frame_nxt[i] = fi_r;
            rank_nxt[i]  = '0;
          end else if (valid_kept[i]) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_tuser;
      pg_r  <= in_tdata[PAGE_BITS-1:0];
      fi_r  <= in_tdata[PAGE_BITS +: FRAME_BITS];
    end
    if (cmd.exec) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
    page_r  <= page_nxt;
    frame_r <= frame_nxt;
    rank_r  <= rank_nxt;
  end

endmodule

@@ sim/fully_associative_lru_tlb_unit_test.sv @@
// Self-checking testbench for fully_associative_lru_tlb_unit: lookups and inserts
// through the input stream, results checked against an in-bench LRU buffer model.
// Depends on fatlb_pkg and the RTL of the unit.
module fully_associative_lru_tlb_unit_test;
  import fatlb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                  action;
    logic [PAGE_BITS-1:0]  vpn;
    logic [FRAME_BITS-1:0] pfn;
  } tlb_req_t;

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame_out;
    logic                  evicted;
    logic [PAGE_BITS-1:0]  evicted_page;
  } tlb_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CAP_W-1:0]      cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // page_number, frame_in
  logic                  in_tuser;   // action
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // frame_out, evicted_page
  logic [OUT_USER_W-1:0] out_tuser;  // hit, evicted

  fully_associative_lru_tlb_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // translation buffer model
  logic                  tlb_valid [ENTRIES];
  logic [PAGE_BITS-1:0]  tlb_page  [ENTRIES];
  logic [FRAME_BITS-1:0] tlb_frame [ENTRIES];
  logic [RANK_W-1:0]     tlb_rank  [ENTRIES];
  logic [CNT_W-1:0]      tlb_used;
  logic [CAP_W-1:0]      tlb_cap;

  tlb_req_t    pending_reqs[$];
  tlb_result_t expected_results[$];
  tlb_req_t    cur_req;

  int  send_idle;
  int  recv_idle;
  int  pushed_count;
  int  accepted_count;
  int  fail_count;
  int  stall_cycles;
  bit  in_fire;
  bit  out_fire;

  function automatic tlb_result_t translate(logic act, logic [PAGE_BITS-1:0] vpn,
                                            logic [FRAME_BITS-1:0] pfn);
    tlb_result_t       r;
    int                cap;
    int                hit_slot;
    int                lru_slot;
    int                free_slot;
    logic [RANK_W-1:0] old_rank;
    r = '0;
    cap = tlb_cap;
    if (cap == 0) return r;
    if (cap > ENTRIES) cap = ENTRIES;
    hit_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_slot < 0 && tlb_valid[i] && tlb_page[i] == vpn) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      r.hit = 1'b1;
      r.frame_out = tlb_frame[hit_slot];
      if (act == ACT_INSERT) tlb_frame[hit_slot] = pfn;
      // promote the hit entry, age only those that were more recent
      old_rank = tlb_rank[hit_slot];
      for (int i = 0; i < ENTRIES; i++) begin
        if (tlb_valid[i] && tlb_rank[i] < old_rank) tlb_rank[i] = tlb_rank[i] + 1'b1;
      end
      tlb_rank[hit_slot] = '0;
      return r;
    end
    if (act == ACT_LOOKUP) return r;
    if (tlb_used >= cap && tlb_used > 0) begin
      lru_slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (tlb_valid[i] && (lru_slot < 0 || tlb_rank[i] > tlb_rank[lru_slot])) lru_slot = i;
      end
      if (lru_slot >= 0) begin
        r.evicted = 1'b1;
        r.evicted_page = tlb_page[lru_slot];
        tlb_valid[lru_slot] = 1'b0;
        tlb_used = tlb_used - 1'b1;
      end
    end
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (free_slot < 0 && !tlb_valid[i]) free_slot = i;
    end
    if (free_slot < 0) return r;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tlb_valid[i]) tlb_rank[i] = tlb_rank[i] + 1'b1;
    end
    tlb_valid[free_slot] = 1'b1;
    tlb_page[free_slot]  = vpn;
    tlb_frame[free_slot] = pfn;
    tlb_rank[free_slot]  = '0;
    tlb_used = tlb_used + 1'b1;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // driver: hold a transaction until it is taken, then advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_fire) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_req = pending_reqs[0];
          pending_reqs.delete(0);
          in_tvalid <= 1'b1;
          in_tuser  <= cur_req.action;
          in_tdata  <= IN_DATA_W'({cur_req.pfn, cur_req.vpn});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor: check results, predict on accepted transactions, watch for hangs
  always @(posedge clk) begin
    tlb_result_t got;
    tlb_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) tlb_valid[i] = 1'b0;
      tlb_used       = '0;
      accepted_count = 0;
      fail_count     = 0;
      stall_cycles   = 0;
      in_fire        = 1'b0;
      out_fire       = 1'b0;
    end else begin
      in_fire  = in_tvalid && in_tready;
      out_fire = out_tvalid && out_tready;
      if (out_fire) begin
        got.hit          = out_tuser[OUT_USER_HIT];
        got.evicted      = out_tuser[OUT_USER_EVICT];
        got.frame_out    = out_tdata[FRAME_BITS-1:0];
        got.evicted_page = out_tdata[FRAME_BITS +: PAGE_BITS];
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: hit=%0b frame=%h evicted=%0b page=%h",
                                 got.hit, got.frame_out, got.evicted, got.evicted_page));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.hit !== want.hit || got.frame_out !== want.frame_out ||
              got.evicted !== want.evicted || got.evicted_page !== want.evicted_page) begin
            note_failure($sformatf(
              "mismatch: exp hit=%0b frame=%h ev=%0b page=%h, got hit=%0b frame=%h ev=%0b page=%h",
              want.hit, want.frame_out, want.evicted, want.evicted_page,
              got.hit, got.frame_out, got.evicted, got.evicted_page));
          end
        end
      end
      if (in_fire) begin
        want = translate(in_tuser, in_tdata[PAGE_BITS-1:0],
                         in_tdata[PAGE_BITS +: FRAME_BITS]);
        expected_results = {expected_results, want};
        accepted_count++;
      end
      if (in_fire || out_fire) begin
        stall_cycles = 0;
      end else if (in_tvalid || expected_results.size() != 0) begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  task automatic add_item(logic act, logic [PAGE_BITS-1:0] vpn, logic [FRAME_BITS-1:0] pfn);
    tlb_req_t r;
    r.action = act;
    r.vpn    = vpn;
    r.pfn    = pfn;
    pending_reqs = {pending_reqs, r};
    pushed_count++;
  endtask

  task automatic wait_drained();
    while (accepted_count != pushed_count || expected_results.size() != 0) @(negedge clk);
    // let the pipeline settle before touching the register
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(int value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CAP_W'(value);
    tlb_cap = CAP_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int                   caps[10];
    logic [PAGE_BITS-1:0] pool[24];
    int                   pool_n;
    int                   n;
    logic                 act;
    logic [PAGE_BITS-1:0] vpn;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    send_idle = 6;
    recv_idle = 78;
    pushed_count = 0;
    tlb_cap = CAP_RESET;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty buffer, extreme pages and frames, rewrite, fill and evict
    add_item(ACT_LOOKUP, '0, '1);
    add_item(ACT_INSERT, '0, '1);
    add_item(ACT_INSERT, '1, '0);
    add_item(ACT_LOOKUP, '0, '0);
    add_item(ACT_LOOKUP, '1, '1);
    add_item(ACT_INSERT, '0, 20'h12345);
    for (int i = 1; i <= 14; i++) add_item(ACT_INSERT, PAGE_BITS'(i), FRAME_BITS'(i * 3));
    add_item(ACT_INSERT, 20'h80000, 20'hABCDE);
    // disabled buffer
    set_capacity(0);
    add_item(ACT_INSERT, 20'h55555, 20'hAAAAA);
    add_item(ACT_LOOKUP, '0, '0);
    // capacity lowered below the number of entries held
    set_capacity(4);
    add_item(ACT_INSERT, 20'h00F00, 20'h0F0F0);
    add_item(ACT_INSERT, 20'hF00FF, 20'h33333);
    add_item(ACT_LOOKUP, 20'h00F00, '0);

    caps = '{31, 1, 16, 8, 0, 2, 17, 5, 15, 16};
    for (int p = 0; p < 10; p++) begin
      set_capacity(caps[p]);
      if (p < 3) begin
        send_idle = 6;
        recv_idle = 78;
      end else if (p < 6) begin
        send_idle = 78;
        recv_idle = 6;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // a small page pool per phase keeps hits and evictions frequent
      pool_n = $urandom_range(24, 2);
      for (int k = 0; k < pool_n; k++) pool[k] = PAGE_BITS'($urandom);
      if ($urandom_range(1)) pool[0] = '0;
      if ($urandom_range(1)) pool[pool_n-1] = '1;
      n = (caps[p] == 0) ? 40 : 150;
      for (int k = 0; k < n; k++) begin
        act = $urandom_range(1);
        if ($urandom_range(99) < 85) vpn = pool[$urandom_range(pool_n - 1)];
        else vpn = PAGE_BITS'($urandom);
        add_item(act, vpn, FRAME_BITS'($urandom));
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
